// ----- hdl/rers_pkg.sv -----
// ----------------------------------------------------------------------------
// Road edge row scan: shared package
// Widths, register indexes, result kinds, the row record that passes from
// the front end to the back end, and the packed result data word.
// ----------------------------------------------------------------------------
package rers_pkg;

   localparam int PIX_W      = 8;
   localparam int COL_W      = 10;
   localparam int CNT_W      = 15;
   localparam int SUM_W      = 24;
   localparam int KIND_W     = 2;
   localparam int CSR_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int RSP_DATA_W = 120;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   // Register values after reset.
   localparam int THRESHOLD_RST = 128;
   localparam int WIDTH_RST     = 160;
   localparam int HEIGHT_RST    = 120;
   localparam int MAX_HEIGHT    = 1024;

   // Result kinds, carried on tuser.
   localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd2;

   // Row record queue.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic             right_found;
      logic [COL_W-1:0] right_col;
      logic             left_found;
      logic [COL_W-1:0] left_col;
      logic [COL_W-1:0] row;
      logic             frame_end;
   } rers_row_rec_type;

   // Result data word, lowest field in the lowest bits.
   typedef struct packed {
      logic [6:0]       pad;
      logic [CNT_W-1:0] total_points;
      logic [SUM_W-1:0] right_col_sum;
      logic [SUM_W-1:0] left_col_sum;
      logic [CNT_W-1:0] right_points;
      logic [CNT_W-1:0] left_points;
      logic [COL_W-1:0] edge_col;
      logic [COL_W-1:0] edge_row;
   } rers_rsp_data_type;

   typedef enum logic [1:0] {
      STEP_RIGHT,
      STEP_LEFT,
      STEP_TOTAL
   } rers_step_type;

endpackage

// ----- hdl/rers_front.sv -----
// ----------------------------------------------------------------------------
// Road edge row scan: front end
// Holds the configuration, classifies each pixel against the threshold and
// the centre column, tracks column and row, and queues a row record at each
// row end that has something to report.
// ----------------------------------------------------------------------------
module rers_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rers_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rers_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rers_pkg::PIX_W-1:0]        req_tdata,
   input  logic                              q_full,
   output logic                              q_push,
   output rers_pkg::rers_row_rec_type        q_rec
);
   import rers_pkg::*;

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CW    = (AW > COL_W) ? AW : COL_W;
   localparam int RST_W = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

   logic [PIX_W-1:0] thr_ff, thr_in;
   logic [AW-1:0]    wlast_ff, wlast_in;
   logic [AW-1:0]    centre_ff, centre_in;
   logic [COL_W-1:0] hm1_ff, hm1_in;

   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] rows_ff, rows_in;
   logic             rf_ff, rf_in;
   logic [COL_W-1:0] rcol_ff, rcol_in;
   logic             lf_ff, lf_in;
   logic [COL_W-1:0] lcol_ff, lcol_in;

   logic [31:0]      v32, w32, h32;
   logic             accept, black, ge_centre, row_end, frame_end;
   logic             rf_n, lf_n;
   logic [COL_W-1:0] rcol_n, lcol_n, rd, row;

   // Configuration: the width and height are clamped once, at write time.
   always_comb begin
      v32       = 32'(csr_wdata);
      w32       = (v32 == 32'd0) ? 32'd1 :
                  (v32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : v32;
      h32       = (v32 == 32'd0) ? 32'd1 :
                  (v32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : v32;
      thr_in    = thr_ff;
      wlast_in  = wlast_ff;
      centre_in = centre_ff;
      hm1_in    = hm1_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD:    thr_in = csr_wdata[PIX_W-1:0];
            CSR_FRAME_WIDTH: begin
               wlast_in  = AW'(w32 - 32'd1);
               centre_in = AW'(w32 >> 1);
            end
            CSR_FRAME_HEIGHT: hm1_in = COL_W'(h32 - 32'd1);
            default: ;
         endcase
      end
   end

   // Pixel classification and row bookkeeping.
   always_comb begin
      row_end    = CW'(col_ff) >= CW'(wlast_ff);
      req_tready = !(q_full && row_end);
      accept     = req_tvalid && req_tready;
      black      = req_tdata < thr_ff;
      ge_centre  = CW'(col_ff) >= CW'(centre_ff);

      rf_n   = rf_ff || (black && ge_centre);
      rcol_n = (black && ge_centre && !rf_ff) ? col_ff : rcol_ff;
      lf_n   = lf_ff || (black && !ge_centre);
      lcol_n = (black && !ge_centre) ? col_ff : lcol_ff;

      rd        = (rows_ff < hm1_ff) ? rows_ff : hm1_ff;
      row       = hm1_ff - rd;
      frame_end = rows_ff >= hm1_ff;

      q_rec.right_found = rf_n;
      q_rec.right_col   = rcol_n;
      q_rec.left_found  = lf_n;
      q_rec.left_col    = lcol_n;
      q_rec.row         = row;
      q_rec.frame_end   = frame_end;
      q_push = accept && row_end && (rf_n || lf_n || frame_end);

      col_in  = col_ff;
      rows_in = rows_ff;
      rf_in   = rf_ff;
      rcol_in = rcol_ff;
      lf_in   = lf_ff;
      lcol_in = lcol_ff;
      if (accept) begin
         if (row_end) begin
            col_in  = '0;
            rows_in = frame_end ? '0 : rows_ff + COL_W'(1);
            rf_in   = 1'b0;
            rcol_in = '0;
            lf_in   = 1'b0;
            lcol_in = '0;
         end else begin
            col_in  = col_ff + COL_W'(1);
            rf_in   = rf_n;
            rcol_in = rcol_n;
            lf_in   = lf_n;
            lcol_in = lcol_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= PIX_W'(THRESHOLD_RST);
         wlast_ff  <= AW'(RST_W - 1);
         centre_ff <= AW'(RST_W / 2);
         hm1_ff    <= COL_W'(HEIGHT_RST - 1);
         col_ff    <= '0;
         rows_ff   <= '0;
         rf_ff     <= 1'b0;
         lf_ff     <= 1'b0;
      end else begin
         thr_ff    <= thr_in;
         wlast_ff  <= wlast_in;
         centre_ff <= centre_in;
         hm1_ff    <= hm1_in;
         col_ff    <= col_in;
         rows_ff   <= rows_in;
         rf_ff     <= rf_in;
         lf_ff     <= lf_in;
      end
   end

   always_ff @(posedge clock) begin
      rcol_ff <= rcol_in;
      lcol_ff <= lcol_in;
   end

endmodule

// ----- hdl/rers_queue.sv -----
// ----------------------------------------------------------------------------
// Road edge row scan: row record queue
// A short first-in first-out buffer of row records between the front end
// and the back end.
// ----------------------------------------------------------------------------
module rers_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  rers_pkg::rers_row_rec_type  push_rec,
   output logic                        full,
   input  logic                        pop,
   output logic                        head_valid,
   output rers_pkg::rers_row_rec_type  head_rec
);
   import rers_pkg::*;

   rers_row_rec_type  mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      full       = cnt_ff == QCNT_W'(QUEUE_DEPTH);
      head_valid = cnt_ff != '0;
      head_rec   = mem[rd_ff];
      wr_in      = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in      = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in     = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_rec;
      end
   end

endmodule

// ----- hdl/rers_back.sv -----
// ----------------------------------------------------------------------------
// Road edge row scan: back end
// Turns queued row records into result beats: applies the point cap, keeps
// the frame counts and column sums, and drives the result output register.
// ----------------------------------------------------------------------------
module rers_back #(
   parameter int MAX_POINTS = 16384
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  rers_pkg::rers_row_rec_type       head_rec,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rers_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [rers_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                             rsp_tlast
);
   import rers_pkg::*;

   localparam int PCW = $clog2(MAX_POINTS + 1);

   rers_step_type     step_ff, step_in;
   logic [PCW-1:0]    pc_ff, pc_in;
   logic [CNT_W-1:0]  lc_ff, lc_in, rc_ff, rc_in;
   logic [SUM_W-1:0]  ls_ff, ls_in, rs_ff, rs_in;
   logic              valid_ff, valid_in;
   rers_rsp_data_type data_ff, data_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic              last_ff, last_in;

   logic              adv, fire, cap_ok, cap_ok2, do_r, do_l, do_t;
   logic              last_r, last_l;
   logic [31:0]       pc32;

   always_comb begin
      adv     = !valid_ff || rsp_tready;
      fire    = adv && head_valid;
      cap_ok  = pc_ff < PCW'(MAX_POINTS);
      cap_ok2 = pc_ff < PCW'(MAX_POINTS - 1);
      pc32    = 32'(pc_ff);

      do_r = head_valid && (step_ff == STEP_RIGHT) && head_rec.right_found && cap_ok;
      do_l = head_valid && (step_ff != STEP_TOTAL) && !do_r && head_rec.left_found
             && cap_ok;
      do_t = head_valid && !do_r && !do_l && head_rec.frame_end;

      // A right point is the last beat unless a left point or totals follow.
      last_r = !(head_rec.left_found && cap_ok2) && !head_rec.frame_end;
      last_l = !head_rec.frame_end;

      step_in  = step_ff;
      pc_in    = pc_ff;
      lc_in    = lc_ff;
      rc_in    = rc_ff;
      ls_in    = ls_ff;
      rs_in    = rs_ff;
      pop      = 1'b0;
      valid_in = adv ? 1'b0 : valid_ff;
      data_in  = data_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;

      if (fire) begin
         data_in = '0;
         unique case (1'b1)
            do_r: begin
               valid_in         = 1'b1;
               kind_in          = KIND_RIGHT;
               last_in          = last_r;
               data_in.edge_row = head_rec.row;
               data_in.edge_col = head_rec.right_col;
               pc_in            = pc_ff + PCW'(1);
               rc_in            = rc_ff + CNT_W'(1);
               rs_in            = rs_ff + SUM_W'(head_rec.right_col);
               pop              = last_r;
               step_in          = last_r ? STEP_RIGHT : STEP_LEFT;
            end
            do_l: begin
               valid_in         = 1'b1;
               kind_in          = KIND_LEFT;
               last_in          = last_l;
               data_in.edge_row = head_rec.row;
               data_in.edge_col = head_rec.left_col;
               pc_in            = pc_ff + PCW'(1);
               lc_in            = lc_ff + CNT_W'(1);
               ls_in            = ls_ff + SUM_W'(head_rec.left_col);
               pop              = last_l;
               step_in          = last_l ? STEP_RIGHT : STEP_TOTAL;
            end
            do_t: begin
               valid_in              = 1'b1;
               kind_in               = KIND_TOTAL;
               last_in               = 1'b1;
               data_in.left_points   = lc_ff;
               data_in.right_points  = rc_ff;
               data_in.left_col_sum  = ls_ff;
               data_in.right_col_sum = rs_ff;
               data_in.total_points  = pc32[CNT_W-1:0];
               pc_in                 = '0;
               lc_in                 = '0;
               rc_in                 = '0;
               ls_in                 = '0;
               rs_in                 = '0;
               pop                   = 1'b1;
               step_in               = STEP_RIGHT;
            end
            default: begin
               // Points found but the cap is reached and no frame end: drop.
               pop     = 1'b1;
               step_in = STEP_RIGHT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_RIGHT;
         pc_ff    <= '0;
         lc_ff    <= '0;
         rc_ff    <= '0;
         ls_ff    <= '0;
         rs_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         pc_ff    <= pc_in;
         lc_ff    <= lc_in;
         rc_ff    <= rc_in;
         ls_ff    <= ls_in;
         rs_ff    <= rs_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PCW'(MAX_POINTS))
      else $error("point count above the cap");

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("record popped from an empty queue");

   a_totals_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && do_t) |=> (pc_ff == '0) && (lc_ff == '0) && (rc_ff == '0))
      else $error("frame counters not cleared after totals");

   a_totals_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (kind_ff == KIND_TOTAL)) |-> last_ff)
      else $error("totals beat not marked last");

endmodule

// ----- hdl/road_edge_row_scan_core.sv -----
// ----------------------------------------------------------------------------
// Road edge row scan core
// Finds the left and right road edge in each row of a thresholded grey
// image and reports per-frame edge counts and column sums.
// ----------------------------------------------------------------------------
// Use: grey pixels enter on the req_ stream, one per beat, rows bottom first
// and each row left to right. At every row end the core sends a right edge
// beat and then a left edge beat on the rsp_ stream when such a point was
// found and the frame's point cap is not yet reached; after the last row of
// a frame it sends a totals beat and clears its frame counters. tlast marks
// the final beat caused by one pixel, and tuser gives the beat's kind.
// A row end pixel's record goes through the queue and then the result
// register. Throughput: one pixel per cycle. A row end produces up to
// three beats, drained one per cycle by the back end; a four-entry row record
// queue absorbs them, so rows of three pixels or more run at full rate and
// narrower rows are slowed by req_tready when the queue fills.
// Reset clears all counters and loads threshold 128, width 160 and height
// 120. When the receiver stalls, the result register holds its beat, the
// queue fills, and only then does req_tready drop, on a row end pixel. Only
// write configuration on the csr_ port while the core is idle; not enforced.
// ----------------------------------------------------------------------------
module road_edge_row_scan_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_POINTS = 16384
) (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration write port.
   input  logic                             csr_we,
   input  logic [rers_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rers_pkg::CSR_W-1:0]       csr_wdata,
   // Pixel stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rers_pkg::PIX_W-1:0]       req_tdata,  // [7:0] pixel
   // Result stream.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [9:0] edge_row, [19:10] edge_col, [34:20] left_points,
   // [49:35] right_points, [73:50] left_col_sum, [97:74] right_col_sum,
   // [112:98] total_points, [119:113] zero
   output logic [rers_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [rers_pkg::KIND_W-1:0]      rsp_tuser,  // [1:0] kind
   output logic                             rsp_tlast
);
   import rers_pkg::*;

   logic             q_full, q_push, q_pop, q_head_valid;
   rers_row_rec_type q_rec, q_head;

   // Front end: configuration, pixel classification and row tracking.
   rers_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_rec      (q_rec)
   );

   // Row records wait here until the back end can issue their beats.
   rers_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (q_rec),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_rec   (q_head)
   );

   // Back end: point cap, frame counters and the result register.
   rers_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_rec   (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- dv/tb_road_edge_row_scan_core.sv -----
// ----------------------------------------------------------------------------
// Road edge row scan core: self-checking testbench
// Feeds grey pixel beats through the core under a range of threshold, width
// and height settings. A behavioural tracker of the edge search predicts
// every edge point and frame totals beat, and each result beat is compared
// field by field with the oldest prediction. The sender runs in bursts with
// gaps and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_road_edge_row_scan_core;
   import rers_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int MAX_PTS       = 16384;
   // Cycles allowed after the last expected beat for the row record queue to
   // empty out rows that produced nothing.
   localparam int SETTLE_CYCLES = 16;
   localparam int WATCHDOG      = 2000000;
   localparam int RANDOM_PIXELS = 24;
   localparam int RANDOM_BEATS  = 8;

   // Index 3 is not a register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // One predicted result beat.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [COL_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CNT_W-1:0]  left_points;
      logic [CNT_W-1:0]  right_points;
      logic [SUM_W-1:0]  left_col_acc;
      logic [SUM_W-1:0]  right_col_acc;
      logic [CNT_W-1:0]  total_points;
      logic              last;
   } edge_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   road_edge_row_scan_core #(
      .MAX_WIDTH  (MAX_W),
      .MAX_POINTS (MAX_PTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Edge search tracker. It holds its own copy of the register settings and
   // of the row and frame state, and is advanced once per accepted pixel.
   // ------------------------------------------------------------------------
   logic [PIX_W-1:0] cfg_threshold = PIX_W'(THRESHOLD_RST);
   logic [CSR_W-1:0] cfg_width     = CSR_W'(WIDTH_RST);
   logic [CSR_W-1:0] cfg_height    = CSR_W'(HEIGHT_RST);

   logic [COL_W-1:0] scan_col        = '0;
   logic [COL_W-1:0] scan_rows       = '0;
   logic             right_seen      = 1'b0;
   logic [COL_W-1:0] right_seen_col  = '0;
   logic             left_seen       = 1'b0;
   logic [COL_W-1:0] left_seen_col   = '0;
   int unsigned      frame_points    = 0;
   logic [CNT_W-1:0] left_tally      = '0;
   logic [CNT_W-1:0] right_tally     = '0;
   logic [SUM_W-1:0] left_col_total  = '0;
   logic [SUM_W-1:0] right_col_total = '0;

   edge_beat_type edge_beats_due[$];
   int            beats_predicted = 0;
   int            pixels_sent     = 0;
   int            fail_count      = 0;

   function automatic void advance_edge_scan(input logic [PIX_W-1:0] pix);
      edge_beat_type beat;
      edge_beat_type row_beats[$];
      int unsigned   w;
      int unsigned   h;
      int unsigned   centre;
      int unsigned   col;
      int unsigned   rd;
      bit            frame_done;
      // Out of range settings are clamped to the usable range.
      w      = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
      h      = (cfg_height == 0) ? 1 :
               ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
      centre = w >> 1;
      col    = scan_col;

      // The right edge keeps the first black pixel from the centre onwards;
      // the left edge keeps the latest black pixel left of centre, which is
      // the one nearest to it.
      if (pix < cfg_threshold) begin
         if (col >= centre) begin
            if (!right_seen) begin
               right_seen     = 1'b1;
               right_seen_col = COL_W'(col);
            end
         end else begin
            left_seen     = 1'b1;
            left_seen_col = COL_W'(col);
         end
      end

      // A counter at or past the last column is a row end, even when the
      // width was lowered part way through the row.
      if (col + 1 >= w) begin
         rd         = (scan_rows < h) ? scan_rows : h - 1;
         frame_done = (scan_rows + 1 >= h);
         if (right_seen && frame_points < MAX_PTS) begin
            beat            = '0;
            beat.kind       = KIND_RIGHT;
            beat.row        = COL_W'(h - 1 - rd);
            beat.col        = right_seen_col;
            row_beats.push_back(beat);
            frame_points++;
            right_tally     = right_tally + 1'b1;
            right_col_total = right_col_total + SUM_W'(right_seen_col);
         end
         if (left_seen && frame_points < MAX_PTS) begin
            beat           = '0;
            beat.kind      = KIND_LEFT;
            beat.row       = COL_W'(h - 1 - rd);
            beat.col       = left_seen_col;
            row_beats.push_back(beat);
            frame_points++;
            left_tally     = left_tally + 1'b1;
            left_col_total = left_col_total + SUM_W'(left_seen_col);
         end
         right_seen     = 1'b0;
         right_seen_col = '0;
         left_seen      = 1'b0;
         left_seen_col  = '0;
         scan_col       = '0;
         if (frame_done) begin
            beat               = '0;
            beat.kind          = KIND_TOTAL;
            beat.left_points   = left_tally;
            beat.right_points  = right_tally;
            beat.left_col_acc  = left_col_total;
            beat.right_col_acc = right_col_total;
            beat.total_points  = CNT_W'(frame_points);
            row_beats.push_back(beat);
            scan_rows       = '0;
            frame_points    = 0;
            left_tally      = '0;
            right_tally     = '0;
            left_col_total  = '0;
            right_col_total = '0;
         end else begin
            scan_rows = scan_rows + 1'b1;
         end
      end else begin
         scan_col = COL_W'(col + 1);
      end

      if (row_beats.size() != 0) row_beats[row_beats.size() - 1].last = 1'b1;
      foreach (row_beats[i]) edge_beats_due.push_back(row_beats[i]);
      beats_predicted += row_beats.size();
   endfunction

   // ------------------------------------------------------------------------
   // Result checking: every accepted beat is matched against the oldest
   // prediction, field by field.
   // ------------------------------------------------------------------------
   rers_rsp_data_type rsp_fields;
   edge_beat_type     beat_due;

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_fields = rsp_tdata;
         if (edge_beats_due.size() == 0) begin
            $display("%0t: result beat with nothing expected: expected none, %s %0d data %h",
                     $time, "actual kind", rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            beat_due = edge_beats_due.pop_front();
            check_field("kind", 32'(beat_due.kind), 32'(rsp_tuser));
            check_field("edge_row", 32'(beat_due.row), 32'(rsp_fields.edge_row));
            check_field("edge_col", 32'(beat_due.col), 32'(rsp_fields.edge_col));
            check_field("left_points", 32'(beat_due.left_points),
                        32'(rsp_fields.left_points));
            check_field("right_points", 32'(beat_due.right_points),
                        32'(rsp_fields.right_points));
            check_field("left_col_sum", 32'(beat_due.left_col_acc),
                        32'(rsp_fields.left_col_sum));
            check_field("right_col_sum", 32'(beat_due.right_col_acc),
                        32'(rsp_fields.right_col_sum));
            check_field("total_points", 32'(beat_due.total_points),
                        32'(rsp_fields.total_points));
            check_field("last", 32'(beat_due.last), 32'(rsp_tlast));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver back-pressure. Long fully ready stretches alternate with long
   // stalls and with short random flicker.
   // ------------------------------------------------------------------------
   int ready_run   = 0;
   bit ready_level = 1'b1;

   always @(negedge clock) begin
      if (ready_run == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               ready_level = 1'b1;
               ready_run   = $urandom_range(20, 60);
            end
            1: begin
               ready_level = 1'b0;
               ready_run   = $urandom_range(1, 12);
            end
            default: begin
               ready_level = 1'($urandom_range(0, 1));
               ready_run   = $urandom_range(1, 4);
            end
         endcase
      end else begin
         ready_run--;
      end
      rsp_tready <= ready_level;
   end

   // ------------------------------------------------------------------------
   // Pixel sender. Tasks are entered and left just after a falling edge. The
   // valid stays high after a beat so that back-to-back beats need no second
   // assignment in one time step; anything that is not a pixel beat first
   // lowers it through drain_results.
   // ------------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         // Most bursts start after a gap, some follow straight on.
         if ($urandom_range(0, 3) != 0) begin
            gap        = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      advance_edge_scan(pix);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Random pixels with roughly the given share below the current threshold.
   task automatic send_random_pixels(input int count, input int black_pct);
      logic [PIX_W-1:0] pix;
      repeat (count) begin
         if (cfg_threshold != 0 && $urandom_range(0, 99) < black_pct)
            pix = PIX_W'($urandom_range(0, cfg_threshold - 1));
         else
            pix = PIX_W'($urandom_range(cfg_threshold, 255));
         send_pixel(pix);
      end
   endtask

   // Waits until every predicted beat has arrived, then lets the core finish
   // any row end that produced nothing.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (edge_beats_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_THRESHOLD:    cfg_threshold = value[PIX_W-1:0];
         CSR_FRAME_WIDTH:  cfg_width     = value;
         CSR_FRAME_HEIGHT: cfg_height    = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_W-1:0] thr_word, input logic [CSR_W-1:0] w,
                            input logic [CSR_W-1:0] h);
      drain_results();
      write_reg(CSR_THRESHOLD, thr_word);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Settings from reset: threshold 128, 160 wide and 120 high. The first
   // eight pixels all lie left of the centre at column 80, and a pixel equal
   // to the threshold is white. The width then drops to twelve, which moves
   // the centre to column 6, so the row ends four pixels later as image row
   // 119. The height then drops to one part way through the frame, so the
   // next row end already closes the frame.
   task automatic test_reset_settings();
      for (int c = 0; c < 8; c++)
         send_pixel((c == 2 || c == 5) ? 8'd127 : ((c == 7) ? 8'd128 : 8'd255));
      drain_results();
      write_reg(CSR_FRAME_WIDTH, 11'd12);
      for (int c = 8; c < 12; c++)
         send_pixel((c == 9) ? 8'd0 : 8'd255);
      drain_results();
      write_reg(CSR_FRAME_HEIGHT, 11'd1);
      // Black either side of the centre, at one below the threshold.
      for (int c = 0; c < 12; c++)
         send_pixel((c == 5 || c == 6) ? 8'd127 : 8'd128);
   endtask

   // Threshold zero leaves nothing black; the top threshold, written with
   // every data bit set, makes everything but 255 black.
   task automatic test_threshold_extremes();
      configure(11'd0, 11'd4, 11'd1);
      repeat (4) send_pixel(8'd0);
      configure(11'h7FF, 11'd4, 11'd1);
      send_pixel(8'd254);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd254);
   endtask

   // A write to the spare index must leave every register as it was.
   task automatic test_spare_index();
      drain_results();
      write_reg(CSR_UNUSED, 11'h7FF);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd128);
      send_pixel(8'd3);
      send_random_pixels(4, 50);
   endtask

   // Zero width and height clamp to one, so every pixel ends a row and a
   // frame. Widths of one to three put the centre at or next to column 0.
   task automatic test_narrow_rows();
      configure(11'd128, 11'd0, 11'd0);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd127);
      send_pixel(8'd128);
      configure(11'd128, 11'd1, 11'd3);
      send_random_pixels(4, 50);
      configure(11'd128, 11'd2, 11'd3);
      send_random_pixels(6, 50);
      configure(11'd100, 11'd3, 11'd2);
      send_random_pixels(6, 60);
   endtask

   // A width above the maximum clamps to it, which puts the centre at column
   // 512. A few pixels into such a row the width drops to six, so the row
   // ends two pixels later with a right edge beyond the new centre.
   task automatic test_widest_rows();
      configure(11'd128, 11'h7FF, 11'd2);
      for (int c = 0; c < 4; c++)
         send_pixel((c == 1 || c == 3) ? 8'd0 : 8'd255);
      drain_results();
      write_reg(CSR_FRAME_WIDTH, 11'd6);
      send_pixel(8'd0);
      send_pixel(8'd255);
   endtask

   // Tallest frames, one pixel per row: the first row fed is row 1023. Part
   // way through the frame the height drops to one, so the row count is past
   // the last row and the next row end closes the frame as row zero.
   task automatic test_tallest_frames();
      configure(11'd128, 11'd1, 11'h7FF);
      send_random_pixels(4, 30);
      drain_results();
      write_reg(CSR_FRAME_HEIGHT, 11'd1);
      send_pixel(8'd0);
      configure(11'd200, 11'd1, 11'(MAX_HEIGHT));
      send_random_pixels(2, 70);
   endtask

   // Register changes part way through a row or a frame.
   task automatic test_mid_stream_changes();
      configure(11'd128, 11'd8, 11'd4);
      // Five pixels into an eight wide row, the width drops to four: the
      // counter is already past the new last column, so the next pixel ends
      // the row.
      send_random_pixels(5, 50);
      drain_results();
      write_reg(CSR_FRAME_WIDTH, 11'd4);
      send_random_pixels(5, 50);
      // Two rows done, the height drops to two: the next row end closes the
      // frame and is reported as row zero.
      drain_results();
      write_reg(CSR_FRAME_HEIGHT, 11'd2);
      send_random_pixels(4, 50);
      // Widening part way through a row simply lengthens it.
      configure(11'd128, 11'd6, 11'd3);
      send_random_pixels(2, 50);
      drain_results();
      write_reg(CSR_FRAME_WIDTH, 11'd10);
      send_random_pixels(8, 40);
   endtask

   // Random settings with whole frames of random pixels, and now and then a
   // cut-short frame so that the next settings land mid-row or mid-frame.
   task automatic test_random_frames();
      int               first_pixel;
      int               first_beat;
      int               eff_w;
      int               eff_h;
      int               count;
      logic [CSR_W-1:0] w;
      logic [CSR_W-1:0] h;
      first_pixel = pixels_sent;
      first_beat  = beats_predicted;
      while (pixels_sent - first_pixel < RANDOM_PIXELS ||
             beats_predicted - first_beat < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = CSR_W'($urandom_range(7, 10));
            default: w = CSR_W'($urandom_range(1, 6));
         endcase
         h     = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 3));
         eff_w = (w == 0) ? 1 : int'(w);
         eff_h = (h == 0) ? 1 : int'(h);
         // Only the low byte of the threshold word counts.
         configure(CSR_W'($urandom_range(0, 2047)), w, h);
         if ($urandom_range(0, 5) == 0)
            count = $urandom_range(1, eff_w * eff_h);
         else
            count = eff_w * eff_h;
         send_random_pixels(count, $urandom_range(0, 100));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_threshold_extremes();
      test_spare_index();
      test_narrow_rows();
      test_widest_rows();
      test_tallest_frames();
      test_mid_stream_changes();
      test_random_frames();

      drain_results();
      if (fail_count == 0)
         $display("road_edge_row_scan_core verification clean");
      else
         $display("road_edge_row_scan_core verification failed");
      $finish;
   end

   // A run that hangs, or leaves predicted beats that never arrive, ends here.
   initial begin
      #(WATCHDOG);
      $display("road_edge_row_scan_core verification failed");
      $finish;
   end

endmodule
